[hdl/kms_pkg.sv]
// Shared types and constants for the keypad matrix scanner.
// No dependencies; used by every module under hdl/.
package kms_pkg;

    localparam int LEVELS_W = 5;
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 16;
    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int DRIVE_W  = 5;
    localparam int POS_W    = 5;
    // Wide enough for any row * column count + column at the parameter limits.
    localparam int POS_FULL_W = 7;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd300;

    typedef struct packed {
        logic [LEVELS_W-1:0] column_levels;
        logic [TIME_W-1:0]   now_ms;
    } t_sample;

    typedef struct packed {
        logic [DRIVE_W-1:0] row_drive;
        logic               key_valid;
        logic [ROW_W-1:0]   key_row;
        logic [COL_W-1:0]   key_col;
        logic [POS_W-1:0]   key_position;
        logic               scan_restart;
    } t_result;

endpackage

[hdl/kms_in_stage.sv]
// Input register for the keypad scanner sample channel.
// Depends on kms_pkg for the sample word type.
module kms_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  kms_pkg::t_sample i_sample,
    input  logic             i_advance,
    output logic             o_valid,
    output kms_pkg::t_sample o_sample
);

    logic             r_valid;
    kms_pkg::t_sample r_sample;
    logic             load_ok;

    // register frees up when empty or when its word moves on this cycle
    assign load_ok = !r_valid || i_advance;
    assign o_stall = !load_ok;
    assign o_valid = r_valid;
    assign o_sample = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_ok) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok && i_valid) begin
            r_sample <= i_sample;
        end
    end

endmodule

[hdl/kms_core.sv]
// Scan state, remembered key, repeat window register and the per-sample decision.
// Depends on kms_pkg for sample and result types.
module kms_core #(
    parameter int ROW_COUNT    = 5,
    parameter int COLUMN_COUNT = 5
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_fire,
    input  kms_pkg::t_sample         i_sample,
    input  logic                     i_cfg_we,
    input  logic [kms_pkg::WIN_W-1:0] i_cfg_data,
    output kms_pkg::t_result         o_result
);

    localparam int COL_LIMIT = (COLUMN_COUNT < kms_pkg::LEVELS_W) ?
                               COLUMN_COUNT : kms_pkg::LEVELS_W;

    logic [kms_pkg::WIN_W-1:0]  r_window;
    logic [kms_pkg::ROW_W-1:0]  r_scan_row;
    logic [kms_pkg::ROW_W-1:0]  r_held_row;
    logic [kms_pkg::COL_W-1:0]  r_held_col;
    logic                       r_held_valid;
    logic [kms_pkg::TIME_W-1:0] r_held_time;

    logic                            hit;
    logic [kms_pkg::COL_W-1:0]       hit_col;
    logic                            same_key;
    logic [kms_pkg::TIME_W-1:0]      elapsed;
    logic                            report;
    logic                            last_row;
    logic                            restart;
    logic [kms_pkg::ROW_W-1:0]       n_scan_row;
    logic [7:0]                      drive_full;
    logic [kms_pkg::POS_FULL_W-1:0]  pos_full;

    // lowest high column wins: walk down so the last match is the lowest
    always_comb begin
        hit     = 1'b0;
        hit_col = '0;
        for (int c = kms_pkg::LEVELS_W - 1; c >= 0; c--) begin
            if (c < COL_LIMIT && i_sample.column_levels[c]) begin
                hit     = 1'b1;
                hit_col = kms_pkg::COL_W'(c);
            end
        end
    end

    assign same_key = r_held_valid && (r_held_row == r_scan_row) && (r_held_col == hit_col);
    assign elapsed  = i_sample.now_ms - r_held_time;
    assign report   = hit && !(same_key &&
                      (elapsed < {{(kms_pkg::TIME_W-kms_pkg::WIN_W){1'b0}}, r_window}));
    assign last_row = ({1'b0, r_scan_row} + 4'd1) >= 4'(ROW_COUNT);
    assign restart  = hit || last_row;
    assign n_scan_row = restart ? '0 : r_scan_row + 3'd1;
    assign drive_full = 8'd1 << n_scan_row;
    assign pos_full   = kms_pkg::POS_FULL_W'(r_scan_row) * kms_pkg::POS_FULL_W'(COLUMN_COUNT)
                      + kms_pkg::POS_FULL_W'(hit_col);

    always_comb begin
        o_result.row_drive    = drive_full[kms_pkg::DRIVE_W-1:0];
        o_result.key_valid    = report;
        o_result.key_row      = report ? r_scan_row : '0;
        o_result.key_col      = report ? hit_col : '0;
        o_result.key_position = report ? pos_full[kms_pkg::POS_W-1:0] : '0;
        o_result.scan_restart = restart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= kms_pkg::WINDOW_RESET;
            r_scan_row   <= '0;
            r_held_row   <= '0;
            r_held_col   <= '0;
            r_held_valid <= 1'b0;
            r_held_time  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (i_fire) begin
                r_scan_row <= n_scan_row;
                if (report) begin
                    r_held_row   <= r_scan_row;
                    r_held_col   <= hit_col;
                    r_held_valid <= 1'b1;
                    r_held_time  <= i_sample.now_ms;
                end
            end
        end
    end

endmodule

[hdl/kms_out_stage.sv]
// Result register for the keypad scanner output channel.
// Depends on kms_pkg for the result word type.
module kms_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  kms_pkg::t_result i_result,
    output logic             o_can_load,
    output logic             o_valid,
    input  logic             i_stall,
    output kms_pkg::t_result o_result
);

    logic             r_valid;
    kms_pkg::t_result r_result;

    assign o_can_load = !r_valid || !i_stall;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

[hdl/keypad_matrix_scanner_top.sv]
// Top level of the keypad matrix scanner.
// Depends on kms_pkg, kms_in_stage, kms_core and kms_out_stage.

// Scans a ROW_COUNT x COLUMN_COUNT key matrix one row per sample word. Each
// accepted word carries the settled column levels of the row currently driven
// and a millisecond timestamp; each produces exactly one result word with the
// row to drive next, an optional key report and a scan-restart flag. A sample
// is taken every clock cycle unless o_in_stall is high; the word waits in the
// input register, then the decision (priority encode plus a 32-bit elapsed-time
// compare) is evaluated as the word moves into the result register.
// The repeat window register may be written whenever the block is idle; its
// write port is always ready.
module keypad_matrix_scanner_top #(
    parameter int ROW_COUNT    = 5,
    parameter int COLUMN_COUNT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [kms_pkg::LEVELS_W-1:0]  i_column_levels,
    input  logic [kms_pkg::TIME_W-1:0]    i_now_ms,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kms_pkg::DRIVE_W-1:0]   o_row_drive,
    output logic                          o_key_valid,
    output logic [kms_pkg::ROW_W-1:0]     o_key_row,
    output logic [kms_pkg::COL_W-1:0]     o_key_col,
    output logic [kms_pkg::POS_W-1:0]     o_key_position,
    output logic                          o_scan_restart,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [kms_pkg::WIN_W-1:0]     i_cfg_data
);

    kms_pkg::t_sample in_sample;
    kms_pkg::t_sample reg_sample;
    kms_pkg::t_result core_result;
    kms_pkg::t_result out_result;
    logic             reg_valid;
    logic             out_can_load;
    logic             fire;

    assign in_sample.column_levels = i_column_levels;
    assign in_sample.now_ms        = i_now_ms;
    assign fire        = reg_valid && out_can_load;
    assign o_cfg_ready = 1'b1;

    kms_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_sample  (in_sample),
        .i_advance (out_can_load),
        .o_valid   (reg_valid),
        .o_sample  (reg_sample)
    );

    kms_core #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_sample   (reg_sample),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_result   (core_result)
    );

    kms_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (reg_valid),
        .i_result   (core_result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_result   (out_result)
    );

    assign o_row_drive    = out_result.row_drive;
    assign o_key_valid    = out_result.key_valid;
    assign o_key_row      = out_result.key_row;
    assign o_key_col      = out_result.key_col;
    assign o_key_position = out_result.key_position;
    assign o_scan_restart = out_result.scan_restart;

endmodule
